### sv/pict_pkg.sv
// shared constants and fixed-point helpers for the point in cylinder test
// no dependencies
package pict_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd6;

  // saturate a wide signed value to sb signed bits, returned as a 32-bit word
  function automatic logic signed [31:0] sat_w(input logic signed [65:0] x, input int sb);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = (66'sd1 <<< (sb - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (x > hi) return hi[31:0];
    else if (x < lo) return lo[31:0];
    else return x[31:0];
  endfunction

  // fixed-point product: floor shift then saturate
  function automatic logic signed [31:0] fx_word(input logic signed [63:0] p, input int f,
                                                 input int sb);
    logic signed [63:0] sh;
    sh = p >>> f;
    return sat_w(66'(sh), sb);
  endfunction

  // magnitude of a signed word as unsigned
  function automatic logic [31:0] mag_w(input logic signed [31:0] x);
    logic signed [32:0] n;
    n = -33'(x);
    return x[31] ? n[31:0] : x;
  endfunction

endpackage

### sv/pict_div.sv
// pipelined restoring divider, one quotient bit per stage, shared divisor
// depends on nothing; quotient assumes numerator not above divisor
module pict_div #(
  parameter int DW    = 33,
  parameter int QB    = 17,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [LANES-1:0][DW-1:0]      num_i,
  input  logic [DW-1:0]                 den_i,
  input  logic [PW-1:0]                 pay_i,
  output logic                          valid_o,
  output logic [LANES-1:0][QB-1:0]      quo_o,
  output logic [PW-1:0]                 pay_o
);

  logic [QB-1:0]                        v_q;
  logic [QB-1:0][LANES-1:0][DW:0]       rem_q, rem_d;
  logic [QB-1:0][LANES-1:0][QB-1:0]     quo_q, quo_d;
  logic [QB-1:0][DW-1:0]                den_q;
  logic [QB-1:0][PW-1:0]                pay_q;

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic          vin;
    logic [DW-1:0] dprev;
    logic [PW-1:0] pay_in;

    // first stage takes the inputs, the others the previous stage
    if (s == 0) begin : g_src_head
      assign vin    = valid_i;
      assign dprev  = den_i;
      assign pay_in = pay_i;
    end else begin : g_src_body
      assign vin    = v_q[s-1];
      assign dprev  = den_q[s-1];
      assign pay_in = pay_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0]   rin;
      logic [DW:0]   dext;
      logic [QB-1:0] qin;
      logic          ge;
      if (s == 0) begin : g_lane_head
        assign rin = {1'b0, num_i[l]};
        assign qin = '0;
      end else begin : g_lane_body
        assign rin = {rem_q[s-1][l][DW-1:0], 1'b0};
        assign qin = quo_q[s-1][l];
      end
      assign dext = {1'b0, dprev};
      always_comb begin
        ge = (rin >= dext);
        rem_d[s][l] = ge ? (rin - dext) : rin;
        quo_d[s][l] = {qin[QB-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d[s];
      quo_q[s] <= quo_d[s];
      den_q[s] <= dprev;
      pay_q[s] <= pay_in;
    end
  end

  assign valid_o = v_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign pay_o   = pay_q[QB-1];

endmodule

### sv/pict_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on nothing; floor of the square root of a 64-bit value
module pict_sqrt #(
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [63:0]   val_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [31:0]   root_o,
  output logic [PW-1:0] pay_o
);

  localparam int STAGES = 32;

  logic [STAGES-1:0]             v_q;
  logic [STAGES-1:0][63:0]       rem_q, rem_d;
  logic [STAGES-1:0][63:0]       root_q, root_d;
  logic [STAGES-1:0][PW-1:0]     pay_q;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0]   rin;
    logic [63:0]   oin;
    logic [64:0]   trial;
    logic          vin;
    logic [PW-1:0] pay_in;

    // first stage takes the inputs, the others the previous stage
    if (s == 0) begin : g_src_head
      assign rin    = val_i;
      assign oin    = 64'd0;
      assign vin    = valid_i;
      assign pay_in = pay_i;
    end else begin : g_src_body
      assign rin    = rem_q[s-1];
      assign oin    = root_q[s-1];
      assign vin    = v_q[s-1];
      assign pay_in = pay_q[s-1];
    end

    always_comb begin
      trial = 65'(oin) + 65'(BIT);
      if (65'(rin) >= trial) begin
        rem_d[s]  = rin - trial[63:0];
        root_d[s] = (oin >> 1) + BIT;
      end else begin
        rem_d[s]  = rin;
        root_d[s] = oin >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d[s];
      root_q[s] <= root_d[s];
      pay_q[s]  <= pay_in;
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign root_o  = root_q[STAGES-1][31:0];
  assign pay_o   = pay_q[STAGES-1];

endmodule

### sv/point_in_cylinder_test.sv
// top level of the point in finite cylinder test
// uses pict_pkg, pict_div and pict_sqrt
module point_in_cylinder_test
  import pict_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  // a fully pipelined tester: one point is taken every clock cycle (busy is
  // never raised) and its transaction comes out on valid_o after passing s1-s3,
  // the axis parameter divider, s4-s7, the square root, s8, the normal divider
  // and s9-s11. the two dividers are bit-per-stage, each FRAC_BITS+1 stages,
  // and the square root of the squared radial distance has 32 stages.
  // the result is shown for exactly one cycle and cannot be held off.
  // configuration must only be written while no transaction is in flight
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    point_x_i,
  input  logic signed [31:0]    point_y_i,
  input  logic signed [31:0]    point_z_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  valid_o,
  output logic                  hit_o,
  output logic signed [17:0]    normal_x_o,
  output logic signed [17:0]    normal_y_o,
  output logic signed [17:0]    normal_z_o,
  output logic signed [31:0]    plane_offset_o,
  output logic signed [31:0]    depth_o
);

  // saturation width: words never exceed 32 bits
  localparam int SATB = (WORD_BITS > 32) ? 32 : WORD_BITS;
  localparam int QB   = FRAC_BITS + 1;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // ---------------------------------------------------------------- config
  logic signed [31:0] base_q [3];
  logic signed [31:0] axis_q [3];
  logic [30:0]        radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0] <= '0;
      base_q[1] <= '0;
      base_q[2] <= '0;
      axis_q[0] <= '0;
      axis_q[1] <= '0;
      axis_q[2] <= ONE;
      radius_q  <= 31'(ONE);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_X: base_q[0] <= cfg_data_i;
        REG_BASE_Y: base_q[1] <= cfg_data_i;
        REG_BASE_Z: base_q[2] <= cfg_data_i;
        REG_AXIS_X: axis_q[0] <= cfg_data_i;
        REG_AXIS_Y: axis_q[1] <= cfg_data_i;
        REG_AXIS_Z: axis_q[2] <= cfg_data_i;
        REG_RADIUS: radius_q  <= cfg_data_i[30:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // no stall anywhere in the pipe
  assign busy = 1'b0;

  // ---------------------------------------------------------------- s1: offset from base
  logic               v1_q;
  logic signed [31:0] d1_q [3];
  logic signed [31:0] pin [3];
  assign pin[0] = point_x_i;
  assign pin[1] = point_y_i;
  assign pin[2] = point_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start & ~busy;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d1_q[i] <= sat_w(66'(pin[i]) - 66'(base_q[i]), SATB);
    end
  end

  // ---------------------------------------------------------------- s2: axis products
  logic               v2_q;
  logic signed [31:0] d2_q [3];
  logic signed [63:0] hd2_q [3];
  logic signed [63:0] hh2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d2_q[i]  <= d1_q[i];
      hd2_q[i] <= axis_q[i] * d1_q[i];
      hh2_q[i] <= axis_q[i] * axis_q[i];
    end
  end

  // ---------------------------------------------------------------- s3: projection and range check
  logic               v3_q;
  logic               miss3_q;
  logic signed [31:0] d3_q [3];
  logic signed [31:0] proj3_q, len3_q;
  logic signed [31:0] proj_d, len_d;

  always_comb begin
    proj_d = sat_w(66'(fx_word(hd2_q[0], FRAC_BITS, SATB)) +
                   66'(fx_word(hd2_q[1], FRAC_BITS, SATB)) +
                   66'(fx_word(hd2_q[2], FRAC_BITS, SATB)), SATB);
    len_d  = sat_w(66'(fx_word(hh2_q[0], FRAC_BITS, SATB)) +
                   66'(fx_word(hh2_q[1], FRAC_BITS, SATB)) +
                   66'(fx_word(hh2_q[2], FRAC_BITS, SATB)), SATB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    // behind the base, zero axis, or beyond the top
    miss3_q <= (proj_d < 0) || (len_d <= 0) || (proj_d > len_d);
    proj3_q <= proj_d;
    len3_q  <= len_d;
    d3_q    <= d2_q;
  end

  // ---------------------------------------------------------------- axis parameter t = proj / len2
  localparam int P1W = 1 + 96;
  logic                  vt;
  logic [0:0][QB-1:0]    t_quo;
  logic [P1W-1:0]        pay1_o;

  pict_div #(
    .DW    (33),
    .QB    (QB),
    .LANES (1),
    .PW    (P1W)
  ) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .num_i   ({1'b0, proj3_q}),
    .den_i   ({1'b0, len3_q}),
    .pay_i   ({miss3_q, d3_q[0], d3_q[1], d3_q[2]}),
    .valid_o (vt),
    .quo_o   (t_quo),
    .pay_o   (pay1_o)
  );

  logic signed [31:0] dt [3];
  logic signed [31:0] t_s;
  assign dt[0] = pay1_o[95:64];
  assign dt[1] = pay1_o[63:32];
  assign dt[2] = pay1_o[31:0];
  assign t_s   = 32'(t_quo[0]);

  // ---------------------------------------------------------------- s4: axis times t
  logic               v4_q, miss4_q;
  logic signed [31:0] d4_q [3];
  logic signed [63:0] ht4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= vt;
  end

  always_ff @(posedge clk_i) begin
    miss4_q <= pay1_o[96];
    for (int i = 0; i < 3; i++) begin
      d4_q[i]  <= dt[i];
      ht4_q[i] <= axis_q[i] * t_s;
    end
  end

  // ---------------------------------------------------------------- s5: radial vector
  logic               v5_q, miss5_q;
  logic signed [31:0] r5_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    miss5_q <= miss4_q;
    for (int i = 0; i < 3; i++) begin
      r5_q[i] <= sat_w(66'(d4_q[i]) - 66'(fx_word(ht4_q[i], FRAC_BITS, SATB)), SATB);
    end
  end

  // ---------------------------------------------------------------- s6: squares
  logic               v6_q, miss6_q;
  logic signed [31:0] r6_q [3];
  logic [63:0]        sq6_q [3];
  logic [61:0]        rr6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    miss6_q <= miss5_q;
    rr6_q   <= radius_q * radius_q;
    for (int i = 0; i < 3; i++) begin
      r6_q[i]  <= r5_q[i];
      sq6_q[i] <= mag_w(r5_q[i]) * mag_w(r5_q[i]);
    end
  end

  // ---------------------------------------------------------------- s7: radial distance squared
  logic               v7_q, miss7_q;
  logic signed [31:0] r7_q [3];
  logic [63:0]        s7_q;
  logic [63:0]        s_d;

  assign s_d = sq6_q[0] + sq6_q[1] + sq6_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else         v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    miss7_q <= miss6_q || (s_d >= 64'(rr6_q));
    s7_q    <= s_d;
    r7_q    <= r6_q;
  end

  // ---------------------------------------------------------------- radial length
  logic        vs;
  logic [31:0] len_s;
  logic [96:0] pay2_o;

  pict_sqrt #(
    .PW (97)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .val_i   (s7_q),
    .pay_i   ({miss7_q, r7_q[0], r7_q[1], r7_q[2]}),
    .valid_o (vs),
    .root_o  (len_s),
    .pay_o   (pay2_o)
  );

  logic signed [31:0] rs [3];
  assign rs[0] = pay2_o[95:64];
  assign rs[1] = pay2_o[63:32];
  assign rs[2] = pay2_o[31:0];

  // ---------------------------------------------------------------- s8: magnitudes for the normal
  logic              v8_q, miss8_q;
  logic [2:0]        neg8_q;
  logic [31:0]       len8_q;
  logic [2:0][32:0]  mag8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else         v8_q <= vs;
  end

  always_ff @(posedge clk_i) begin
    miss8_q <= pay2_o[96];
    len8_q  <= len_s;
    for (int i = 0; i < 3; i++) begin
      neg8_q[i] <= rs[i][31];
      mag8_q[i] <= {1'b0, mag_w(rs[i])};
    end
  end

  // ---------------------------------------------------------------- normal division
  localparam int P3W = 1 + 3 + 32;
  logic              vn;
  logic [2:0][QB-1:0] nq;
  logic [P3W-1:0]    pay3_o;

  pict_div #(
    .DW    (33),
    .QB    (QB),
    .LANES (3),
    .PW    (P3W)
  ) u_div_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .num_i   (mag8_q),
    .den_i   ({1'b0, len8_q}),
    .pay_i   ({miss8_q, neg8_q, len8_q}),
    .valid_o (vn),
    .quo_o   (nq),
    .pay_o   (pay3_o)
  );

  logic [31:0] len_n;
  logic [2:0]  neg_n;
  assign len_n = pay3_o[31:0];
  assign neg_n = pay3_o[34:32];

  // ---------------------------------------------------------------- s9: signed, clamped normal
  logic               v9_q, miss9_q;
  logic [31:0]        len9_q;
  logic signed [31:0] n9_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else         v9_q <= vn;
  end

  always_ff @(posedge clk_i) begin
    miss9_q <= pay3_o[35];
    len9_q  <= len_n;
    for (int i = 0; i < 3; i++) begin
      logic signed [31:0] qv;
      qv = 32'(nq[i]);
      if (qv > ONE) qv = ONE;
      if (len_n == '0) begin
        // point on the axis: normal points along +z
        n9_q[i] <= (i == 2) ? ONE : 32'sd0;
      end else begin
        n9_q[i] <= neg_n[i] ? -qv : qv;
      end
    end
  end

  // ---------------------------------------------------------------- s10: normal dot base products
  logic               v10_q, miss10_q;
  logic [31:0]        len10_q;
  logic signed [31:0] n10_q [3];
  logic signed [63:0] nb10_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v10_q <= 1'b0;
    else         v10_q <= v9_q;
  end

  always_ff @(posedge clk_i) begin
    miss10_q <= miss9_q;
    len10_q  <= len9_q;
    for (int i = 0; i < 3; i++) begin
      n10_q[i]  <= n9_q[i];
      nb10_q[i] <= n9_q[i] * base_q[i];
    end
  end

  // ---------------------------------------------------------------- s11: result register
  logic               val_q, hit_q;
  logic signed [17:0] nx_q, ny_q, nz_q;
  logic signed [31:0] off_q, dep_q;
  logic signed [31:0] off_d, dep_d;

  always_comb begin
    off_d = sat_w(66'(fx_word(nb10_q[0], FRAC_BITS, SATB)) +
                  66'(fx_word(nb10_q[1], FRAC_BITS, SATB)) +
                  66'(fx_word(nb10_q[2], FRAC_BITS, SATB)) +
                  66'({1'b0, radius_q}), SATB);
    dep_d = sat_w(66'({1'b0, radius_q}) - 66'({1'b0, len10_q}), SATB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      val_q <= v10_q;
      hit_q <= v10_q & ~miss10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // a miss clears every field
    nx_q  <= miss10_q ? '0 : n10_q[0][17:0];
    ny_q  <= miss10_q ? '0 : n10_q[1][17:0];
    nz_q  <= miss10_q ? '0 : n10_q[2][17:0];
    off_q <= miss10_q ? '0 : off_d;
    dep_q <= miss10_q ? '0 : dep_d;
  end

  assign valid_o        = val_q;
  assign hit_o          = hit_q;
  assign normal_x_o     = nx_q;
  assign normal_y_o     = ny_q;
  assign normal_z_o     = nz_q;
  assign plane_offset_o = off_q;
  assign depth_o        = dep_q;

  // ---------------------------------------------------------------- checks
  a_hit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> valid_o) else $error("hit without result strobe");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0 &&
                             plane_offset_o == 0 && depth_o == 0))
    else $error("miss transaction carries nonzero fields");

  a_hit_normal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> (normal_x_o != 0 || normal_y_o != 0 || normal_z_o != 0))
    else $error("hit with zero normal");

  a_hit_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> (!depth_o[31] && depth_o != 0))
    else $error("hit with non-positive depth");

endmodule
